// ----- rtl/core/tpa_pkg.sv -----
package tpa_pkg;

  // Field and port widths
  localparam int TICK_W   = 16;
  localparam int CFG_W    = 8;
  localparam int WAIT_W   = 15;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W   = REG_IDX_W + 2;
  localparam int DATA_W   = 32;

  // Timing constants, in 0.5 us timer counts
  localparam int DELAY_SCALE       = 111;
  localparam int DELAY_OFFSET      = 9;
  localparam int STARTUP_SPAN      = 160;
  localparam int RUN_SPAN          = 130;
  localparam int PULSE_WIDTH       = 200;
  localparam int WAIT_MAX          = 32767;
  localparam int STARTUP_END_ANGLE = 140;

  // State after reset
  localparam int RESET_ANGLE  = 170;
  localparam int RESET_TARGET = 140;

  // Remainder lanes of the tick divider
  localparam int NUM_LANES   = 3;
  localparam int LANE_PULSE  = 0;
  localparam int LANE_SWITCH = 1;
  localparam int LANE_RAMP   = 2;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_INIT  = 2'd3
  } func_e;

  // Switch event codes; the fourth code is not an event
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PLUS  = 2'd1;
  localparam logic [1:0] EV_MINUS = 2'd2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INIT_ANGLE = 3'd0,
    REG_STOP_ANGLE = 3'd1,
    REG_SLOW_LEVEL = 3'd2,
    REG_MID_LEVEL  = 3'd3,
    REG_FAST_LEVEL = 3'd4,
    REG_PULSE_DIV  = 3'd5,
    REG_SWITCH_DIV = 3'd6,
    REG_RAMP_DIV   = 3'd7
  } reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] initial_angle;
    logic [CFG_W-1:0] stop_angle;
    logic [CFG_W-1:0] slow_level;
    logic [CFG_W-1:0] mid_level;
    logic [CFG_W-1:0] fast_level;
    logic [CFG_W-1:0] pulse_divisor;
    logic [CFG_W-1:0] switch_divisor;
    logic [CFG_W-1:0] ramp_divisor;
  } cfg_t;

  typedef struct packed {
    logic load;    // capture the accepted item, clear the lanes
    logic step;    // one remainder bit in every lane
    logic mult;    // register the delay and wait products
    logic commit;  // update state, load the result register
  } cmd_t;

  typedef struct packed {
    logic div_last;  // the lanes take their last bit this cycle
  } status_t;

endpackage

// ----- rtl/core/tpa_in_if.sv -----
interface tpa_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [tpa_pkg::TICK_W-1:0]  tick_count;
  logic [1:0]                  switch_event;
  logic                        switch_busy;

  modport source (
    output valid, func, tick_count, switch_event, switch_busy,
    input  ready
  );

  modport sink (
    input  valid, func, tick_count, switch_event, switch_busy,
    output ready
  );
endinterface

// ----- rtl/core/tpa_out_if.sv -----
interface tpa_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  angle;
  logic [tpa_pkg::WAIT_W-1:0]  fire_delay;
  logic                        fire_pulse;
  logic [tpa_pkg::WAIT_W-1:0]  after_wait;
  logic                        angle_changed;
  logic                        startup_active;

  modport source (
    output valid, angle, fire_delay, fire_pulse, after_wait, angle_changed,
           startup_active,
    input  ready
  );

  modport sink (
    input  valid, angle, fire_delay, fire_pulse, after_wait, angle_changed,
           startup_active,
    output ready
  );
endinterface

// ----- rtl/core/tpa_regs.sv -----
module tpa_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpa_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpa_pkg::DATA_W-1:0]   pwdata,
  output logic [tpa_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output tpa_pkg::cfg_t                cfg_o
);

  tpa_pkg::cfg_t                    cfg_q;
  tpa_pkg::reg_e                    idx;
  logic [tpa_pkg::CFG_W-1:0]        rd_val;
  logic [tpa_pkg::CFG_W-1:0]        wr_val;

  assign idx    = tpa_pkg::reg_e'(paddr[tpa_pkg::ADDR_W-1:2]);
  assign wr_val = pwdata[tpa_pkg::CFG_W-1:0];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_angle  <= 8'd170;
      cfg_q.stop_angle     <= 8'd170;
      cfg_q.slow_level     <= 8'd140;
      cfg_q.mid_level      <= 8'd90;
      cfg_q.fast_level     <= 8'd10;
      cfg_q.pulse_divisor  <= 8'd2;
      cfg_q.switch_divisor <= 8'd2;
      cfg_q.ramp_divisor   <= 8'd2;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        tpa_pkg::REG_INIT_ANGLE: cfg_q.initial_angle  <= wr_val;
        tpa_pkg::REG_STOP_ANGLE: cfg_q.stop_angle     <= wr_val;
        tpa_pkg::REG_SLOW_LEVEL: cfg_q.slow_level     <= wr_val;
        tpa_pkg::REG_MID_LEVEL:  cfg_q.mid_level      <= wr_val;
        tpa_pkg::REG_FAST_LEVEL: cfg_q.fast_level     <= wr_val;
        tpa_pkg::REG_PULSE_DIV:  cfg_q.pulse_divisor  <= wr_val;
        tpa_pkg::REG_SWITCH_DIV: cfg_q.switch_divisor <= wr_val;
        tpa_pkg::REG_RAMP_DIV:   cfg_q.ramp_divisor   <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tpa_pkg::REG_INIT_ANGLE: rd_val = cfg_q.initial_angle;
      tpa_pkg::REG_STOP_ANGLE: rd_val = cfg_q.stop_angle;
      tpa_pkg::REG_SLOW_LEVEL: rd_val = cfg_q.slow_level;
      tpa_pkg::REG_MID_LEVEL:  rd_val = cfg_q.mid_level;
      tpa_pkg::REG_FAST_LEVEL: rd_val = cfg_q.fast_level;
      tpa_pkg::REG_PULSE_DIV:  rd_val = cfg_q.pulse_divisor;
      tpa_pkg::REG_SWITCH_DIV: rd_val = cfg_q.switch_divisor;
      tpa_pkg::REG_RAMP_DIV:   rd_val = cfg_q.ramp_divisor;
      default:                 rd_val = '0;
    endcase
  end

  assign prdata = tpa_pkg::DATA_W'(rd_val);

endmodule

// ----- rtl/core/tpa_ctrl.sv -----
module tpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  tpa_pkg::status_t  status_i,
  output tpa_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_MULTIPLY,
    ST_APPLY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The result register may be reloaded in the cycle its transfer completes
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step   = (state_q == ST_DIVIDE);
    cmd_o.mult   = (state_q == ST_MULTIPLY);
    cmd_o.commit = (state_q == ST_APPLY) && slot_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DIVIDE;
      ST_DIVIDE:   if (status_i.div_last) state_d = ST_MULTIPLY;
      ST_MULTIPLY: state_d = ST_APPLY;
      ST_APPLY:    if (slot_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/tpa_dp.sv -----
module tpa_dp #(
  parameter int ANGLE_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tpa_pkg::cmd_t                cmd_i,
  output tpa_pkg::status_t             status_o,
  input  tpa_pkg::cfg_t                cfg_i,
  input  logic [1:0]                   func_i,
  input  logic [tpa_pkg::TICK_W-1:0]   tick_count_i,
  input  logic [1:0]                   switch_event_i,
  input  logic                         switch_busy_i,
  output logic [7:0]                   angle_o,
  output logic [tpa_pkg::WAIT_W-1:0]   fire_delay_o,
  output logic                         fire_pulse_o,
  output logic [tpa_pkg::WAIT_W-1:0]   after_wait_o,
  output logic                         angle_changed_o,
  output logic                         startup_active_o
);

  localparam int AW    = ANGLE_BITS;
  localparam int PW    = ANGLE_BITS + 12;
  localparam int CNT_W = $clog2(tpa_pkg::TICK_W);
  localparam int CW    = tpa_pkg::CFG_W;

  localparam logic signed [PW-1:0] SCALE_S  = PW'(tpa_pkg::DELAY_SCALE);
  localparam logic signed [PW-1:0] OFFSET_S = PW'(tpa_pkg::DELAY_OFFSET);
  localparam logic signed [PW-1:0] SPAN_ST  = PW'(tpa_pkg::STARTUP_SPAN);
  localparam logic signed [PW-1:0] SPAN_RUN = PW'(tpa_pkg::RUN_SPAN);
  localparam logic signed [PW-1:0] PULSE_S  = PW'(tpa_pkg::PULSE_WIDTH);
  localparam logic signed [PW-1:0] WMAX_S   = PW'(tpa_pkg::WAIT_MAX);

  function automatic logic [tpa_pkg::WAIT_W-1:0] sat_wait(input logic signed [PW-1:0] v);
    logic [tpa_pkg::WAIT_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > WMAX_S) begin
      r = tpa_pkg::WAIT_W'(tpa_pkg::WAIT_MAX);
    end else begin
      r = v[tpa_pkg::WAIT_W-1:0];
    end
    return r;
  endfunction

  // Captured item
  tpa_pkg::func_e               func_q;
  logic [tpa_pkg::TICK_W-1:0]   tick_q;
  logic                         tick_zero_q;
  logic [1:0]                   ev_q;
  logic                         busy_q;

  // Remainder lanes
  logic [CW-1:0]                rem_q [tpa_pkg::NUM_LANES];
  logic [CW-1:0]                rem_d [tpa_pkg::NUM_LANES];
  logic [CW-1:0]                lane_div [tpa_pkg::NUM_LANES];
  logic [CW:0]                  lane_sh [tpa_pkg::NUM_LANES];
  logic [tpa_pkg::NUM_LANES-1:0] hit;
  logic [CNT_W-1:0]             cnt_q;

  // Products
  logic signed [PW-1:0]         off_s, span_s;
  logic signed [PW-1:0]         dprod_q, wprod_q;

  // Controller state
  logic [AW-1:0]                angle_q, target_q;
  logic [1:0]                   pend_q;
  logic                         startup_q;

  // Apply step
  logic [AW-1:0]                slow_a, mid_a, fast_a;
  logic [1:0]                   pend_lat, pend_sw, pend_new;
  logic [AW-1:0]                tgt_sw, tgt_new, base, angle_new;
  logic                         ramp_en, moved, startup_new;

  assign lane_div[tpa_pkg::LANE_PULSE]  = cfg_i.pulse_divisor;
  assign lane_div[tpa_pkg::LANE_SWITCH] = cfg_i.switch_divisor;
  assign lane_div[tpa_pkg::LANE_RAMP]   = cfg_i.ramp_divisor;

  // Restoring remainder, one tick bit per cycle in every lane
  always_comb begin
    for (int l = 0; l < tpa_pkg::NUM_LANES; l++) begin
      lane_sh[l] = {rem_q[l], tick_q[tpa_pkg::TICK_W-1]};
      if (lane_sh[l] >= {1'b0, lane_div[l]}) begin
        rem_d[l] = CW'(lane_sh[l] - {1'b0, lane_div[l]});
      end else begin
        rem_d[l] = lane_sh[l][CW-1:0];
      end
      hit[l] = (lane_div[l] == '0) || tick_zero_q || (rem_q[l] == '0);
    end
  end

  assign status_o.div_last = cmd_i.step && (cnt_q == CNT_W'(tpa_pkg::TICK_W - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q      <= tpa_pkg::func_e'(func_i);
      tick_q      <= tick_count_i;
      tick_zero_q <= (tick_count_i == '0);
      ev_q        <= switch_event_i;
      busy_q      <= switch_busy_i;
      cnt_q       <= '0;
      for (int l = 0; l < tpa_pkg::NUM_LANES; l++) begin
        rem_q[l] <= '0;
      end
    end else if (cmd_i.step) begin
      tick_q <= {tick_q[tpa_pkg::TICK_W-2:0], 1'b0};
      cnt_q  <= cnt_q + CNT_W'(1);
      for (int l = 0; l < tpa_pkg::NUM_LANES; l++) begin
        rem_q[l] <= rem_d[l];
      end
    end
  end

  // Delay and wait products from the angle and startup flag before this item
  assign off_s  = $signed(PW'(angle_q)) - OFFSET_S;
  assign span_s = startup_q ? SPAN_ST : SPAN_RUN;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      dprod_q <= off_s * SCALE_S;
      wprod_q <= (span_s - off_s) * SCALE_S;
    end
  end

  assign slow_a = AW'(cfg_i.slow_level);
  assign mid_a  = AW'(cfg_i.mid_level);
  assign fast_a = AW'(cfg_i.fast_level);

  // Latch the event, then the level change on switch ticks
  always_comb begin
    pend_lat = ((ev_q == tpa_pkg::EV_PLUS) || (ev_q == tpa_pkg::EV_MINUS)) ? ev_q : pend_q;
    pend_sw  = pend_lat;
    tgt_sw   = target_q;
    if (hit[tpa_pkg::LANE_SWITCH] && !busy_q) begin
      if (pend_lat == tpa_pkg::EV_PLUS) begin
        if (target_q == slow_a) begin
          tgt_sw = mid_a;
        end else if (target_q == mid_a) begin
          tgt_sw = fast_a;
        end
        pend_sw = tpa_pkg::EV_NONE;
      end else if (pend_lat == tpa_pkg::EV_MINUS) begin
        if (target_q == slow_a) begin
          tgt_sw = slow_a;
        end else if (target_q == mid_a) begin
          tgt_sw = slow_a;
        end else if (target_q == fast_a) begin
          tgt_sw = mid_a;
        end
        pend_sw = tpa_pkg::EV_NONE;
      end
    end
  end

  always_comb begin
    unique case (func_q)
      tpa_pkg::FUNC_TICK: begin
        base     = angle_q;
        tgt_new  = tgt_sw;
        pend_new = pend_sw;
        ramp_en  = hit[tpa_pkg::LANE_RAMP];
      end
      tpa_pkg::FUNC_START: begin
        base     = slow_a;
        tgt_new  = target_q;
        pend_new = pend_q;
        ramp_en  = 1'b1;
      end
      tpa_pkg::FUNC_STOP: begin
        base     = AW'(cfg_i.stop_angle);
        tgt_new  = target_q;
        pend_new = pend_q;
        ramp_en  = 1'b1;
      end
      tpa_pkg::FUNC_INIT: begin
        base     = AW'(cfg_i.initial_angle);
        tgt_new  = slow_a;
        pend_new = tpa_pkg::EV_NONE;
        ramp_en  = 1'b1;
      end
      default: begin
        base     = angle_q;
        tgt_new  = target_q;
        pend_new = pend_q;
        ramp_en  = 1'b0;
      end
    endcase
  end

  // One ramp step toward the target
  always_comb begin
    angle_new = base;
    moved     = 1'b0;
    if (ramp_en && (base > tgt_new)) begin
      angle_new = base - AW'(1);
      moved     = 1'b1;
    end else if (ramp_en && (base < tgt_new)) begin
      angle_new = base + AW'(1);
      moved     = 1'b1;
    end
    if (func_q == tpa_pkg::FUNC_INIT) begin
      startup_new = 1'b1;
    end else if (ramp_en && (angle_new == AW'(tpa_pkg::STARTUP_END_ANGLE))) begin
      startup_new = 1'b0;
    end else begin
      startup_new = startup_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q   <= AW'(tpa_pkg::RESET_ANGLE);
      target_q  <= AW'(tpa_pkg::RESET_TARGET);
      pend_q    <= tpa_pkg::EV_NONE;
      startup_q <= 1'b1;
    end else if (cmd_i.commit) begin
      angle_q   <= angle_new;
      target_q  <= tgt_new;
      pend_q    <= pend_new;
      startup_q <= startup_new;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      angle_o          <= angle_new[7:0];
      angle_changed_o  <= moved;
      startup_active_o <= startup_new;
      if (func_q == tpa_pkg::FUNC_TICK) begin
        fire_delay_o <= sat_wait(dprod_q);
        fire_pulse_o <= hit[tpa_pkg::LANE_PULSE];
        after_wait_o <= sat_wait(wprod_q - PULSE_S);
      end else begin
        fire_delay_o <= '0;
        fire_pulse_o <= 1'b0;
        after_wait_o <= '0;
      end
    end
  end

endmodule

// ----- rtl/core/triac_phase_angle_soft_ramp.sv -----
// Phase-angle triac speed controller with a soft ramp. Each item on in_i is a
// tick (func 0) or a start, stop or init command; each gives exactly one
// result on out_o: the firing angle after the item, the firing delay and the
// wait after the fixed 200-count pulse (0.5 us counts, clamped to 0..32767),
// the pulse flag, whether the ramp moved the angle, and the startup flag.
// Pulse, switch and ramp actions happen on ticks whose count is a multiple of
// the matching divisor register; a divisor of 0 or a tick count of 0 means
// every tick. One item is in work at a time and goes through an accept step,
// a divide step in which three remainder lanes walk the 16-bit tick count
// one bit per cycle, a step for the delay and wait products, and an apply
// step for the switch and ramp step and the result register load. A new item
// is taken while the previous result waits for its transfer; the apply step
// holds only while that result is still unread. Registers sit at byte address
// 4*i on the APB port and must be written only while the block is idle; the
// block itself does not enforce this.
module triac_phase_angle_soft_ramp #(
  parameter int ANGLE_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tpa_in_if.sink                      in_i,
  tpa_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpa_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpa_pkg::DATA_W-1:0]  pwdata,
  output logic [tpa_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  tpa_pkg::cfg_t    cfg;
  tpa_pkg::cmd_t    cmd;
  tpa_pkg::status_t status;

  // Configuration registers
  tpa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: accept, divide, multiply, apply
  tpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Remainder lanes, products, angle state and result register
  tpa_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_i            (cfg),
    .func_i           (in_i.func),
    .tick_count_i     (in_i.tick_count),
    .switch_event_i   (in_i.switch_event),
    .switch_busy_i    (in_i.switch_busy),
    .angle_o          (out_o.angle),
    .fire_delay_o     (out_o.fire_delay),
    .fire_pulse_o     (out_o.fire_pulse),
    .after_wait_o     (out_o.after_wait),
    .angle_changed_o  (out_o.angle_changed),
    .startup_active_o (out_o.startup_active)
  );

  // Drop ready for the cycles an accepted item is in work
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while an item is in work");

  // A committed item always shows up as a valid result
  a_commit_shows_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid)
    else $error("result register loaded without valid");

  // Apply never overlaps an input transfer
  a_commit_not_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !in_i.ready)
    else $error("apply step while accepting input");

  // The last remainder bit is followed by the multiply step
  a_div_then_mult : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_last |=> cmd.mult)
    else $error("multiply step missed after the divide");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import tpa_pkg::*;

  // The package names three event codes; the fourth value must be ignored
  localparam logic [1:0] EV_INVALID = 2'd3;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the long receiver hold plus one item latency.
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS      = 195;
  localparam int unsigned NUM_PHASES       = 8;
  // Leave margin at the end of the run
  localparam int unsigned TAIL_CYCLES      = 40;

  typedef struct packed {
    func_e       func;
    logic [15:0] tick;
    logic [1:0]  sw_event;
    logic        sw_busy;
  } tick_item_t;

  typedef struct packed {
    logic [7:0]        angle;
    logic [WAIT_W-1:0] fire_delay;
    logic              fire_pulse;
    logic [WAIT_W-1:0] after_wait;
    logic              angle_changed;
    logic              startup_active;
  } ctrl_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  // Configuration port, driven only by the stimulus process
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tpa_in_if  in_bus();
  tpa_out_if out_bus();

  triac_phase_angle_soft_ramp dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Items waiting to be offered, and results the controller must still give
  tick_item_t   pending_ticks[$];
  ctrl_result_t expected_results[$];
  int unsigned  queued_count;
  int unsigned  mismatch_count;

  // Idle behavior of both sides, changed per phase
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit          hold_request;

  // ---------------------------------------------------------------------------
  // Controller predictor: own copy of the angle state and the register file.
  // Register copies change only when the port write completes.
  // ---------------------------------------------------------------------------
  logic [7:0] shadow_cfg [NUM_REGS];
  logic [7:0] pred_angle;
  logic [7:0] pred_target;
  logic [1:0] pred_pending;
  logic       pred_startup;

  // A divisor of zero and a tick count of zero both mean "act on this tick"
  function automatic logic on_multiple(logic [15:0] tick, logic [7:0] div);
    if (div == 8'd0 || tick == 16'd0) return 1'b1;
    return (tick % div) == 16'd0;
  endfunction

  // Clamp a timer count into the 15-bit output range
  function automatic logic [WAIT_W-1:0] clamp_counts(int v);
    if (v < 0) return '0;
    if (v > WAIT_MAX) return WAIT_W'(WAIT_MAX);
    return v[WAIT_W-1:0];
  endfunction

  // Move the angle one step toward the target; the startup flag drops
  // once the angle lands on the end-of-startup angle
  function automatic logic ramp_toward_target();
    logic moved;
    moved = 1'b0;
    if (pred_angle > pred_target) begin
      pred_angle = pred_angle - 8'd1;
      moved = 1'b1;
    end else if (pred_angle < pred_target) begin
      pred_angle = pred_angle + 8'd1;
      moved = 1'b1;
    end
    if (pred_angle == STARTUP_END_ANGLE) pred_startup = 1'b0;
    return moved;
  endfunction

  function automatic ctrl_result_t controller_step(tick_item_t it);
    ctrl_result_t r;
    int           offset;
    int           span;
    logic [7:0]   slow;
    logic [7:0]   mid;
    logic [7:0]   fast;
    r    = '0;
    slow = shadow_cfg[REG_SLOW_LEVEL];
    mid  = shadow_cfg[REG_MID_LEVEL];
    fast = shadow_cfg[REG_FAST_LEVEL];
    case (it.func)
      FUNC_TICK: begin
        // Latch the event first; timing uses the angle and flag before
        // this tick's switch check and ramp step
        if (it.sw_event == EV_PLUS || it.sw_event == EV_MINUS) pred_pending = it.sw_event;
        offset = int'(pred_angle) - DELAY_OFFSET;
        span   = pred_startup ? STARTUP_SPAN : RUN_SPAN;
        r.fire_delay = clamp_counts(offset * DELAY_SCALE);
        r.fire_pulse = on_multiple(it.tick, shadow_cfg[REG_PULSE_DIV]);
        r.after_wait = clamp_counts((span - offset) * DELAY_SCALE - PULSE_WIDTH);
        if (on_multiple(it.tick, shadow_cfg[REG_SWITCH_DIV]) && !it.sw_busy) begin
          // Levels are matched slow, mid, fast in that order; a target that
          // matches none stays put but the event is still consumed
          if (pred_pending == EV_PLUS) begin
            if (pred_target == slow) pred_target = mid;
            else if (pred_target == mid) pred_target = fast;
            pred_pending = EV_NONE;
          end else if (pred_pending == EV_MINUS) begin
            if (pred_target == slow) pred_target = slow;
            else if (pred_target == mid) pred_target = slow;
            else if (pred_target == fast) pred_target = mid;
            pred_pending = EV_NONE;
          end
        end
        if (on_multiple(it.tick, shadow_cfg[REG_RAMP_DIV])) r.angle_changed = ramp_toward_target();
      end
      FUNC_START: begin
        pred_angle = slow;
        r.angle_changed = ramp_toward_target();
      end
      FUNC_STOP: begin
        pred_angle = shadow_cfg[REG_STOP_ANGLE];
        r.angle_changed = ramp_toward_target();
      end
      FUNC_INIT: begin
        pred_angle   = shadow_cfg[REG_INIT_ANGLE];
        pred_target  = slow;
        pred_pending = EV_NONE;
        r.angle_changed = ramp_toward_target();
        // Init re-enters startup even if its own step reached the end angle
        pred_startup = 1'b1;
      end
      default: ;
    endcase
    r.angle          = pred_angle;
    r.startup_active = pred_startup;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer the head of the pending queue, hold it until the
  // transfer, then advance. Predict each item at the edge it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : tick_sender
    tick_item_t taken;
    if (!rst_ni) begin
      in_bus.valid        <= 1'b0;
      in_bus.func         <= FUNC_TICK;
      in_bus.tick_count   <= '0;
      in_bus.switch_event <= EV_NONE;
      in_bus.switch_busy  <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        taken = pending_ticks.pop_front();
        expected_results.push_back(controller_step(taken));
      end
      // Only pick a new item once the current one is gone
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_bus.valid        <= 1'b1;
          in_bus.func         <= pending_ticks[0].func;
          in_bus.tick_count   <= pending_ticks[0].tick;
          in_bus.switch_event <= pending_ticks[0].sw_event;
          in_bus.switch_busy  <= pending_ticks[0].sw_busy;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus one long hold on request so the block
  // fills up and pushes back on its input.
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_taken;

  always @(posedge clk_i or negedge rst_ni) begin : result_receiver
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_taken    <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_left     <= LONG_HOLD_CYCLES;
      hold_taken    <= 1'b1;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every transfer against the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    ctrl_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: angle %0d", out_bus.angle);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("angle", want.angle, out_bus.angle);
        check_field("fire_delay", want.fire_delay, out_bus.fire_delay);
        check_field("fire_pulse", want.fire_pulse, out_bus.fire_pulse);
        check_field("after_wait", want.after_wait, out_bus.after_wait);
        check_field("angle_changed", want.angle_changed, out_bus.angle_changed);
        check_field("startup_active", want.startup_active, out_bus.startup_active);
      end
    end
  end

  // Restart the count on any transfer or register access
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(func_e f, logic [15:0] tick, logic [1:0] ev, logic busy);
    tick_item_t it;
    it.func     = f;
    it.tick     = tick;
    it.sw_event = ev;
    it.sw_busy  = busy;
    pending_ticks.push_back(it);
    queued_count++;
  endtask

  // Setup cycle, access cycle, then hold until the slave takes it
  task automatic write_reg(reg_e idx, logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_cfg[idx] = value;
  endtask

  task automatic load_config(cfg_t c);
    write_reg(REG_INIT_ANGLE, c.initial_angle);
    write_reg(REG_STOP_ANGLE, c.stop_angle);
    write_reg(REG_SLOW_LEVEL, c.slow_level);
    write_reg(REG_MID_LEVEL,  c.mid_level);
    write_reg(REG_FAST_LEVEL, c.fast_level);
    write_reg(REG_PULSE_DIV,  c.pulse_divisor);
    write_reg(REG_SWITCH_DIV, c.switch_divisor);
    write_reg(REG_RAMP_DIV,   c.ramp_divisor);
  endtask

  // A realistic run: a command, then consecutive ticks with occasional
  // switch presses, a held switch now and then, and a stray command
  task automatic queue_session(int unsigned len);
    logic [15:0] tick;
    logic [1:0]  ev;
    int unsigned roll;
    // Sometimes start just below the wrap of the tick counter
    tick = ($urandom_range(9) == 0) ? 16'hFFF0 : 16'($urandom);
    case ($urandom_range(9))
      0:       queue_item(FUNC_START, 16'($urandom), 2'($urandom), 1'($urandom));
      1:       queue_item(FUNC_STOP, 16'($urandom), 2'($urandom), 1'($urandom));
      default: queue_item(FUNC_INIT, 16'($urandom), 2'($urandom), 1'($urandom));
    endcase
    repeat (len) begin
      if ($urandom_range(99) < 4) begin
        queue_item(func_e'($urandom_range(1, 3)), 16'($urandom), 2'($urandom), 1'($urandom));
      end else begin
        roll = $urandom_range(99);
        if (roll < 8) ev = EV_PLUS;
        else if (roll < 15) ev = EV_MINUS;
        else if (roll < 17) ev = EV_INVALID;
        else ev = EV_NONE;
        queue_item(FUNC_TICK, tick, ev, $urandom_range(99) < 15);
        tick = tick + 16'd1;
      end
    end
  endtask

  task automatic wait_for_drain();
    while (pending_ticks.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t        cfg;
    int unsigned phase_end;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 1'b0;
    queued_count       = 0;
    mismatch_count     = 0;

    shadow_cfg[REG_INIT_ANGLE] = 8'd170;
    shadow_cfg[REG_STOP_ANGLE] = 8'd170;
    shadow_cfg[REG_SLOW_LEVEL] = 8'd140;
    shadow_cfg[REG_MID_LEVEL]  = 8'd90;
    shadow_cfg[REG_FAST_LEVEL] = 8'd10;
    shadow_cfg[REG_PULSE_DIV]  = 8'd2;
    shadow_cfg[REG_SWITCH_DIV] = 8'd2;
    shadow_cfg[REG_RAMP_DIV]   = 8'd2;
    pred_angle   = 8'(RESET_ANGLE);
    pred_target  = 8'(RESET_TARGET);
    pred_pending = EV_NONE;
    pred_startup = 1'b1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed part on the reset register values, no idling.
    // Tick zero acts on every divisor; the top count is odd.
    queue_item(FUNC_TICK, 16'd0, EV_NONE, 1'b0);
    queue_item(FUNC_TICK, 16'hFFFF, EV_INVALID, 1'b1);
    // Latch plus off a switch tick, keep it pending through a busy switch tick
    queue_item(FUNC_TICK, 16'd1, EV_PLUS, 1'b1);
    queue_item(FUNC_TICK, 16'd2, EV_NONE, 1'b1);
    queue_item(FUNC_TICK, 16'd4, EV_NONE, 1'b0);
    // Walk the levels up past fast, then down past slow
    queue_item(FUNC_TICK, 16'd6, EV_PLUS, 1'b0);
    queue_item(FUNC_TICK, 16'd8, EV_PLUS, 1'b0);
    queue_item(FUNC_TICK, 16'd10, EV_MINUS, 1'b0);
    queue_item(FUNC_TICK, 16'd12, EV_MINUS, 1'b0);
    queue_item(FUNC_TICK, 16'd14, EV_MINUS, 1'b0);
    queue_item(FUNC_TICK, 16'h5555, EV_INVALID, 1'b1);
    queue_item(FUNC_TICK, 16'hAAAA, EV_NONE, 1'b0);
    // Commands ignore the switch fields and give no pulse timing
    queue_item(FUNC_START, 16'hFFFF, EV_PLUS, 1'b1);
    queue_item(FUNC_STOP, 16'd0, EV_INVALID, 1'b1);
    queue_item(FUNC_INIT, 16'h8000, EV_MINUS, 1'b0);
    // Init drops a latched event
    queue_item(FUNC_TICK, 16'd17, EV_PLUS, 1'b0);
    queue_item(FUNC_INIT, 16'd3, EV_NONE, 1'b0);
    queue_item(FUNC_TICK, 16'd18, EV_NONE, 1'b0);
    queue_item(FUNC_TICK, 16'd19, EV_MINUS, 1'b0);
    queue_item(FUNC_TICK, 16'd20, EV_NONE, 1'b0);
    queue_item(FUNC_TICK, 16'd22, EV_PLUS, 1'b1);
    queue_item(FUNC_TICK, 16'd24, EV_NONE, 1'b0);
    wait_for_drain();

    for (int unsigned ph = 1; ph <= NUM_PHASES; ph++) begin
      case (ph)
        // Low extremes, every divisor one
        1: cfg = '{8'd10, 8'd10, 8'd170, 8'd90, 8'd10, 8'd1, 8'd1, 8'd1};
        // Zero divisors act every tick; top angles
        2: cfg = '{8'd255, 8'd255, 8'd140, 8'd90, 8'd10, 8'd0, 8'd0, 8'd0};
        // Largest divisors; angles under the offset clamp the delay to zero
        3: cfg = '{8'd0, 8'd5, 8'd170, 8'd100, 8'd20, 8'd255, 8'd255, 8'd255};
        // Slow and mid collide, so level matching order matters
        4: cfg = '{8'd150, 8'd130, 8'd120, 8'd120, 8'd10, 8'd2, 8'd3, 8'd1};
        default: begin
          cfg.initial_angle  = 8'($urandom_range(255));
          cfg.stop_angle     = 8'($urandom_range(255));
          cfg.slow_level     = 8'($urandom_range(255));
          cfg.mid_level      = 8'($urandom_range(255));
          cfg.fast_level     = 8'($urandom_range(255));
          cfg.pulse_divisor  = 8'($urandom_range(ph == NUM_PHASES ? 255 : 4));
          cfg.switch_divisor = 8'($urandom_range(ph == NUM_PHASES ? 255 : 4));
          cfg.ramp_divisor   = 8'($urandom_range(ph == NUM_PHASES ? 255 : 4));
        end
      endcase
      load_config(cfg);

      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase

      // Mostly well-formed sessions, the rest fully random items
      phase_end = queued_count + PHASE_ITEMS;
      while (queued_count < phase_end) begin
        if ($urandom_range(9) == 0) begin
          queue_item(func_e'($urandom_range(3)), 16'($urandom), 2'($urandom), 1'($urandom));
        end else begin
          queue_session($urandom_range(20, 100));
        end
      end

      // Hold the output while the input keeps offering, once in the run
      if (ph == 4) hold_request = 1'b1;
      wait_for_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
